FILE: rtl/bst_pkg.sv
// Shared constants, codes and control types of the barrier table.
package bst_pkg;

    localparam int BARRIERS = 16;
    localparam int WAITERS  = 16;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int GOAL_W  = 8;
    localparam int IDX_W   = 4;
    localparam int WID_W   = 8;
    localparam int KIND_W  = 3;

    localparam int BIDX_W  = (BARRIERS > 1) ? $clog2(BARRIERS) : 1;
    localparam int FILL_W  = $clog2(WAITERS + 1);
    localparam int STORE_DEPTH = BARRIERS * WAITERS;
    localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 2'd0,
        OP_WAIT    = 2'd1,
        OP_DESTROY = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INDEX    = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_BLOCKED  = 3'd2,
        KIND_RELEASED = 3'd3,
        KIND_CLEARED  = 3'd4,
        KIND_OVERFLOW = 3'd5
    } kind_t;

    typedef struct packed {
        logic  capture;
        logic  search;
        logic  alloc;
        logic  blocked_wr;
        logic  count_clr;
        logic  entry_clr;
        logic  fill_clr;
        logic  slot_inc;
        logic  rd_en;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_ok;
        logic hit_any;
        logic free_any;
        logic goal_hit;
        logic queue_full;
        logic slot_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/bst_ram.sv
// Generic single-port RAM with registered read data.
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bst_datapath.sv
// Entry table, waiter queues, request capture and result register.
module bst_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bst_pkg::ctrl_cmd_t           cmd,
    output bst_pkg::dp_status_t          st,
    input  logic [bst_pkg::KEY_W-1:0]    s_barrier_key,
    input  logic [bst_pkg::GOAL_W-1:0]   s_goal_count,
    input  logic [bst_pkg::IDX_W-1:0]    s_entry_index,
    input  logic [bst_pkg::WID_W-1:0]    s_waiter_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bst_pkg::KIND_W-1:0]   m_kind,
    output logic [bst_pkg::IDX_W-1:0]    m_result_index,
    output logic [bst_pkg::WID_W-1:0]    m_released_id,
    output logic                         m_last
);

    // Captured request.
    logic [bst_pkg::KEY_W-1:0]  key_reg;
    logic [bst_pkg::GOAL_W-1:0] goal_reg;
    logic [bst_pkg::IDX_W-1:0]  idx_reg;
    logic [bst_pkg::WID_W-1:0]  wid_reg;

    // Entry table.
    logic                        valid_reg  [bst_pkg::BARRIERS];
    logic [bst_pkg::KEY_W-1:0]   ekey_reg   [bst_pkg::BARRIERS];
    logic [bst_pkg::GOAL_W-1:0]  egoal_reg  [bst_pkg::BARRIERS];
    logic [bst_pkg::GOAL_W-1:0]  count_reg  [bst_pkg::BARRIERS];
    logic [bst_pkg::FILL_W-1:0]  fill_reg   [bst_pkg::BARRIERS];

    logic [bst_pkg::BARRIERS-1:0] hit_vec_reg;
    logic [bst_pkg::BARRIERS-1:0] free_vec_reg;
    logic [bst_pkg::FILL_W-1:0]   slot_reg;

    // Result register.
    logic                        m_valid_reg;
    logic [bst_pkg::KIND_W-1:0]  m_kind_reg;
    logic [bst_pkg::IDX_W-1:0]   m_index_reg;
    logic [bst_pkg::WID_W-1:0]   m_id_reg;
    logic                        m_last_reg;

    logic [bst_pkg::BIDX_W-1:0]  idx_lo;
    logic [bst_pkg::BIDX_W-1:0]  first_hit;
    logic [bst_pkg::BIDX_W-1:0]  first_free;
    logic [bst_pkg::BIDX_W-1:0]  chosen;
    logic [bst_pkg::GOAL_W-1:0]  cnt_inc;
    logic [bst_pkg::FILL_W-1:0]  cur_fill;
    logic [bst_pkg::FILL_W-1:0]  slot_sel;
    logic [bst_pkg::ADDR_W-1:0]  ram_addr;
    logic [bst_pkg::WID_W-1:0]   ram_rdata;
    logic [bst_pkg::IDX_W-1:0]   res_index;
    logic [bst_pkg::WID_W-1:0]   res_id;

    assign idx_lo   = idx_reg[bst_pkg::BIDX_W-1:0];
    assign cnt_inc  = count_reg[idx_lo] + bst_pkg::GOAL_W'(1);
    assign cur_fill = fill_reg[idx_lo];

    // Lowest set bit of the registered match and free vectors.
    always_comb begin
        first_hit  = '0;
        first_free = '0;
        for (int i = bst_pkg::BARRIERS - 1; i >= 0; i--) begin
            if (hit_vec_reg[i]) begin
                first_hit = bst_pkg::BIDX_W'(i);
            end
            if (free_vec_reg[i]) begin
                first_free = bst_pkg::BIDX_W'(i);
            end
        end
    end

    assign chosen = (|hit_vec_reg) ? first_hit : first_free;

    assign st.idx_ok     = (32'(idx_reg) < bst_pkg::BARRIERS);
    assign st.hit_any    = |hit_vec_reg;
    assign st.free_any   = |free_vec_reg;
    assign st.goal_hit   = (cnt_inc == egoal_reg[idx_lo]);
    assign st.queue_full = (32'(cur_fill) >= bst_pkg::WAITERS);
    assign st.slot_done  = (slot_reg >= cur_fill);
    assign st.out_free   = !m_valid_reg || m_ready;

    // A blocked arrival writes at the fill slot; a drain reads at the drain slot.
    assign slot_sel = cmd.blocked_wr ? cur_fill : slot_reg;
    assign ram_addr = bst_pkg::ADDR_W'(32'(idx_lo) * bst_pkg::WAITERS + 32'(slot_sel));

    bst_ram #(
        .WIDTH (bst_pkg::WID_W),
        .DEPTH (bst_pkg::STORE_DEPTH)
    ) u_waiter_ram (
        .aclk  (aclk),
        .we    (cmd.blocked_wr),
        .re    (cmd.rd_en),
        .addr  (ram_addr),
        .wdata (wid_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        case (cmd.emit_kind)
            bst_pkg::KIND_INDEX:    res_index = bst_pkg::IDX_W'(chosen);
            bst_pkg::KIND_FULL:     res_index = '0;
            default:                res_index = idx_reg;
        endcase
        case (cmd.emit_kind)
            bst_pkg::KIND_BLOCKED:  res_id = wid_reg;
            bst_pkg::KIND_RELEASED: res_id = ram_rdata;
            default:                res_id = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg  <= s_barrier_key;
            goal_reg <= s_goal_count;
            idx_reg  <= s_entry_index;
            wid_reg  <= s_waiter_id;
        end
        if (cmd.search) begin
            for (int i = 0; i < bst_pkg::BARRIERS; i++) begin
                hit_vec_reg[i]  <= valid_reg[i] && (ekey_reg[i] == key_reg);
                free_vec_reg[i] <= !valid_reg[i];
            end
        end
        if (cmd.emit) begin
            m_kind_reg  <= cmd.emit_kind;
            m_index_reg <= res_index;
            m_id_reg    <= res_id;
            m_last_reg  <= cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bst_pkg::BARRIERS; i++) begin
                valid_reg[i] <= 1'b0;
                ekey_reg[i]  <= '0;
                egoal_reg[i] <= '0;
                count_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.alloc) begin
                valid_reg[chosen] <= 1'b1;
                ekey_reg[chosen]  <= key_reg;
                egoal_reg[chosen] <= goal_reg;
            end
            if (cmd.entry_clr) begin
                valid_reg[idx_lo] <= 1'b0;
                ekey_reg[idx_lo]  <= '0;
                egoal_reg[idx_lo] <= '0;
                count_reg[idx_lo] <= '0;
            end
            if (cmd.count_clr) begin
                count_reg[idx_lo] <= '0;
            end
            if (cmd.blocked_wr) begin
                count_reg[idx_lo] <= cnt_inc;
                fill_reg[idx_lo]  <= cur_fill + bst_pkg::FILL_W'(1);
            end
            if (cmd.fill_clr) begin
                fill_reg[idx_lo] <= '0;
            end
            if (cmd.capture) begin
                slot_reg <= '0;
            end else if (cmd.slot_inc) begin
                slot_reg <= slot_reg + bst_pkg::FILL_W'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_result_index = m_index_reg;
    assign m_released_id  = m_id_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    // A result must never overwrite one that has not been taken.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while occupied");

    // Queue depth stays within its bound whenever a queue is written or drained.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.blocked_wr || cmd.rd_en) |-> (32'(cur_fill) <= bst_pkg::WAITERS))
        else $error("waiter queue fill beyond capacity");

    // A queue write only happens when there is room and the goal is not met.
    a_block_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.blocked_wr |-> (!st.queue_full && !st.goal_hit))
        else $error("waiter queued into a full queue or at goal");

    // An allocation marks the chosen entry valid.
    a_alloc_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |=> valid_reg[$past(chosen)])
        else $error("allocated entry not marked valid");
`endif

endmodule

FILE: rtl/bst_ctrl.sv
// Request sequencer: dispatches each operation and walks the release drain.
module bst_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic [bst_pkg::OP_W-1:0]  s_op,
    output logic                      s_ready,
    input  bst_pkg::dp_status_t       st,
    output bst_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INIT,
        S_WAIT,
        S_DESTROY,
        S_DRAIN,
        S_REL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        cmd.emit_kind = bst_pkg::KIND_CLEARED;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        bst_pkg::OP_INIT:    state_next = S_SEARCH;
                        bst_pkg::OP_WAIT:    state_next = S_WAIT;
                        bst_pkg::OP_DESTROY: state_next = S_DESTROY;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                state_next = S_INIT;
            end
            S_INIT: begin
                cmd.emit_kind = (st.hit_any || st.free_any) ? bst_pkg::KIND_INDEX
                                                            : bst_pkg::KIND_FULL;
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.alloc     = !st.hit_any && st.free_any;
                    state_next    = S_IDLE;
                end
            end
            S_WAIT: begin
                if (!st.idx_ok) begin
                    state_next = S_IDLE;
                end else if (st.goal_hit) begin
                    cmd.count_clr = 1'b1;
                    state_next    = S_DRAIN;
                end else if (st.queue_full) begin
                    cmd.emit_kind = bst_pkg::KIND_OVERFLOW;
                    if (st.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.emit_kind = bst_pkg::KIND_BLOCKED;
                    if (st.out_free) begin
                        cmd.blocked_wr = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.emit_last  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_DESTROY: begin
                if (!st.idx_ok) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.entry_clr = 1'b1;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!st.slot_done) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_REL;
                end else if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.fill_clr  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_REL: begin
                cmd.emit_kind = bst_pkg::KIND_RELEASED;
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.slot_inc = 1'b1;
                    state_next   = S_DRAIN;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    // A request is only taken from idle.
    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (state_reg == S_IDLE) && s_valid)
        else $error("request captured outside idle");

    // Every released waiter is followed by a return to the drain step.
    a_rel_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REL) && st.out_free |=> (state_reg == S_DRAIN))
        else $error("drain did not resume after a release");

    // The closing result of a request always returns the sequencer to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && cmd.emit_last |=> (state_reg == S_IDLE))
        else $error("final result without return to idle");
`endif

endmodule

FILE: rtl/barrier_sync_table_unit.sv
// Top level of the counting barrier table: sequencer plus table datapath.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op, barrier_key, goal_count, entry_index, waiter_id
//  m_      | out       | m_valid / m_ready  | kind, result_index, released_id, last
//
// Init passes through accept, key compare across all entries, then pick and answer.
// A blocked or overflowing wait answers straight after accept; a destroy or goal-reaching
// wait then drains its queue, the drain being paced by the waiter RAM read.
// Reset is synchronous on aresetn low and clears every entry and queue.
// A stalled m_ready holds the sequencer in place; a new request is taken while the
// last result of the previous one still waits in the output register.
module barrier_sync_table_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bst_pkg::OP_W-1:0]    s_op,
    input  logic [bst_pkg::KEY_W-1:0]   s_barrier_key,
    input  logic [bst_pkg::GOAL_W-1:0]  s_goal_count,
    input  logic [bst_pkg::IDX_W-1:0]   s_entry_index,
    input  logic [bst_pkg::WID_W-1:0]   s_waiter_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bst_pkg::KIND_W-1:0]  m_kind,
    output logic [bst_pkg::IDX_W-1:0]   m_result_index,
    output logic [bst_pkg::WID_W-1:0]   m_released_id,
    output logic                        m_last
);

    bst_pkg::ctrl_cmd_t  cmd;
    bst_pkg::dp_status_t st;

    bst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    bst_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .s_barrier_key  (s_barrier_key),
        .s_goal_count   (s_goal_count),
        .s_entry_index  (s_entry_index),
        .s_waiter_id    (s_waiter_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_result_index (m_result_index),
        .m_released_id  (m_released_id),
        .m_last         (m_last)
    );

endmodule
